/* rtl/tsc_pkg.sv */
// shared types and constants for the test sequence controller
package tsc_pkg;

    // default number of command queue entries
    localparam int QUEUE_DEPTH_DEF = 8;

    // command code width as stored in the queue
    localparam int CMD_W = 4;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE      = 4'd0,
        CMD_START     = 4'd1,
        CMD_CHIP_IN   = 4'd2,
        CMD_LOT_OK    = 4'd3,
        CMD_LOT_BAD   = 4'd4,
        CMD_READ_FAIL = 4'd5,
        CMD_CASSETTE  = 4'd6,
        CMD_MEAS_DONE = 4'd7,
        CMD_CALC_DONE = 4'd8,
        CMD_RESET     = 4'd9
    } cmd_t;

    // inspection sequence states
    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_WAIT_CHIP = 4'd1,
        ST_VALIDATE  = 4'd2,
        ST_WAIT_CAS  = 4'd3,
        ST_READY     = 4'd4,
        ST_MEASURING = 4'd5,
        ST_CALC      = 4'd6,
        ST_RESULT    = 4'd7,
        ST_ERROR     = 4'd8
    } seq_state_t;

    // lot verdict codes
    localparam logic [1:0] LOT_VALID   = 2'd0;
    localparam logic [1:0] LOT_INVALID = 2'd1;

    // queue requests from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

/* rtl/tsc_cmd_queue.sv */
// command queue: single-port-write, registered-read memory with pointers and fill count
module tsc_cmd_queue #(
    parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tsc_pkg::queue_ctrl_t     ctrl,
    input  logic [tsc_pkg::CMD_W-1:0] wr_data,
    output logic [tsc_pkg::CMD_W-1:0] rd_data,
    output logic [CNT_W-1:0]         count,
    output logic                     full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [tsc_pkg::CMD_W-1:0] mem [QUEUE_DEPTH];
    logic [tsc_pkg::CMD_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]          wr_ptr_reg;
    logic [PTR_W-1:0]          wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg;
    logic [PTR_W-1:0]          rd_ptr_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      do_push;
    logic                      do_pop;
    logic                      empty;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = ctrl.push && !full;
    assign do_pop  = ctrl.pop && !empty;
    assign count   = count_reg;
    assign rd_data = rd_data_reg;

    // pointer wrap and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (do_pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // the sequencer never pushes into a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push && !ctrl.pop |-> !full)
        else $error("push while queue full");

    // the sequencer never pops an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> !empty)
        else $error("pop while queue empty");

    // fill count advances on an accepted push without a pop
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not advance on push");

endmodule

/* rtl/test_sequence_controller_with_cmd_fifo.sv */
// top level: inspection sequencer with command queue and result register
//
// Each input transfer gives exactly one result transfer. A submit (tuser 0)
// stores the command in the queue, or drops it and reports accepted = 0 when
// the queue is full; the result is loaded once the output register is free.
// A run (tuser 1) drains the queue one command per cycle through the queue
// memory's single registered read port, then retries a held start and, on
// first arrival in the validate-lot state, queues the lot verdict. A stalled
// result register delays the loading of the result. The input side is ready
// again as soon as the result is loaded into the output register, even while
// that result is still waiting to be taken. No clearing pass follows reset.
module test_sequence_controller_with_cmd_fifo #(
    parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [3:0] command, [4] power_ready, [6:5] lot_result, [7] zero
    input  logic        s_tuser,  // [0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // [0] accepted, [4:1] seq_state_out, [8:5] queue_level,
                                  // [9] start_waiting, [15:10] zero
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        P_IDLE,
        P_DRAIN,
        P_FINAL,
        P_DONE
    } phase_t;

    phase_t                    phase_reg, phase_next;
    tsc_pkg::seq_state_t       seq_reg, seq_next;
    logic                      held_reg, held_next;
    logic                      checked_reg, checked_next;
    logic                      acc_reg, acc_next;
    logic                      power_reg, power_next;
    logic [1:0]                verdict_reg, verdict_next;
    logic                      pend_reg, pend_next;
    logic                      m_valid_reg, m_valid_next;
    logic [15:0]               m_data_reg, m_data_next;

    tsc_pkg::queue_ctrl_t      q_ctrl;
    logic [tsc_pkg::CMD_W-1:0] q_wdata;
    logic [tsc_pkg::CMD_W-1:0] q_rdata;
    logic [CNT_W-1:0]          q_count;
    logic                      q_full;
    logic [CNT_W+3:0]          level_ext;
    logic [3:0]                level;
    logic [tsc_pkg::CMD_W-1:0] lot_cmd;

    tsc_cmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_data (q_wdata),
        .rd_data (q_rdata),
        .count   (q_count),
        .full    (q_full)
    );

    assign s_tready  = (phase_reg == P_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign level_ext = {4'b0000, q_count};
    assign level     = level_ext[3:0];

    // lot verdict to command; unknown code counts as read failure
    always_comb begin
        case (verdict_reg)
            tsc_pkg::LOT_VALID:   lot_cmd = tsc_pkg::CMD_LOT_OK;
            tsc_pkg::LOT_INVALID: lot_cmd = tsc_pkg::CMD_LOT_BAD;
            default:              lot_cmd = tsc_pkg::CMD_READ_FAIL;
        endcase
    end

    // sequencing of submit and run passes
    always_comb begin
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        held_next    = held_reg;
        checked_next = checked_reg;
        acc_next     = acc_reg;
        power_next   = power_reg;
        verdict_next = verdict_reg;
        pend_next    = 1'b0;
        q_ctrl       = '0;
        q_wdata      = s_tdata[3:0];
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        case (phase_reg)
            P_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        q_ctrl.push = !q_full;
                        acc_next    = !q_full;
                        phase_next  = P_DONE;
                    end else begin
                        power_next   = s_tdata[4];
                        verdict_next = s_tdata[6:5];
                        acc_next     = 1'b1;
                        phase_next   = P_DRAIN;
                    end
                end
            end
            P_DRAIN: begin
                // issue one read a cycle, apply the command in the cycle after its read
                if (q_count != '0) begin
                    q_ctrl.pop = 1'b1;
                    pend_next  = 1'b1;
                end
                if (pend_reg) begin
                    case (q_rdata)
                        tsc_pkg::CMD_START: begin
                            if (seq_reg == tsc_pkg::ST_IDLE) begin
                                if (power_reg) begin
                                    held_next = 1'b0;
                                    seq_next  = tsc_pkg::ST_WAIT_CHIP;
                                end else begin
                                    held_next = 1'b1;
                                end
                            end
                        end
                        tsc_pkg::CMD_CHIP_IN: begin
                            if (seq_reg == tsc_pkg::ST_WAIT_CHIP) begin
                                seq_next     = tsc_pkg::ST_VALIDATE;
                                checked_next = 1'b0;
                            end
                        end
                        tsc_pkg::CMD_LOT_OK: begin
                            if (seq_reg == tsc_pkg::ST_VALIDATE) begin
                                seq_next = tsc_pkg::ST_WAIT_CAS;
                            end
                        end
                        tsc_pkg::CMD_LOT_BAD, tsc_pkg::CMD_READ_FAIL: begin
                            if (seq_reg == tsc_pkg::ST_VALIDATE) begin
                                seq_next = tsc_pkg::ST_ERROR;
                            end
                        end
                        tsc_pkg::CMD_CASSETTE: begin
                            if (seq_reg == tsc_pkg::ST_WAIT_CAS) begin
                                seq_next = tsc_pkg::ST_READY;
                            end
                        end
                        tsc_pkg::CMD_MEAS_DONE: begin
                            if (seq_reg == tsc_pkg::ST_MEASURING) begin
                                seq_next = tsc_pkg::ST_CALC;
                            end
                        end
                        tsc_pkg::CMD_CALC_DONE: begin
                            if (seq_reg == tsc_pkg::ST_CALC) begin
                                seq_next = tsc_pkg::ST_RESULT;
                            end
                        end
                        tsc_pkg::CMD_RESET: begin
                            held_next = 1'b0;
                            seq_next  = tsc_pkg::ST_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                if (q_count == '0 && !pend_reg) begin
                    phase_next = P_FINAL;
                end
            end
            P_FINAL: begin
                // retry a held start once power is up
                if (held_reg && seq_reg == tsc_pkg::ST_IDLE && power_reg) begin
                    held_next = 1'b0;
                    seq_next  = tsc_pkg::ST_WAIT_CHIP;
                end
                // queue the lot verdict once per visit to validate
                if (seq_reg == tsc_pkg::ST_VALIDATE && !checked_reg && !q_full) begin
                    q_ctrl.push  = 1'b1;
                    q_wdata      = lot_cmd;
                    checked_next = 1'b1;
                end
                phase_next = P_DONE;
            end
            P_DONE: begin
                // load the result once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b000000, held_reg, level, seq_reg, acc_reg};
                    phase_next   = P_IDLE;
                end
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= P_IDLE;
            seq_reg     <= tsc_pkg::ST_IDLE;
            held_reg    <= 1'b0;
            checked_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            held_reg    <= held_next;
            checked_reg <= checked_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg     <= acc_next;
        power_reg   <= power_next;
        verdict_reg <= verdict_next;
        m_data_reg  <= m_data_next;
    end

    // a held start only exists while the sequence sits in idle
    a_held_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> seq_reg == tsc_pkg::ST_IDLE)
        else $error("start held outside idle");

    // the queue is fully drained when the final checks run
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == P_FINAL |-> q_count == '0 && !pend_reg)
        else $error("final checks before queue drained");

    // a result is loaded only when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == P_DONE && m_valid_reg && !m_tready |=> phase_reg == P_DONE)
        else $error("result dropped while output stalled");

endmodule
